/* hdl/spsc_pkg.sv */
package spsc_pkg;

   // Fixed widths of the result word.
   localparam int COUNT_W = 13;
   localparam int TOTAL_W = 25;
   localparam int ERR_W   = 2;

   // The running total saturates at its all-ones value.
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Result status codes.
   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_LONG  = 2'd2
   } err_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ROOT,
      ST_FILL_SP,
      ST_SP_TEST,
      ST_SP_CHK,
      ST_SP_STRIKE,
      ST_FILL_SEG,
      ST_SG_TEST,
      ST_SG_CHK,
      ST_DIV,
      ST_OFF,
      ST_SG_STRIKE,
      ST_BCD,
      ST_CNT_TEST,
      ST_CNT_CHK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic root_init;
      logic root_step;
      logic k_two;
      logic sp_fill;
      logic sp_init;
      logic map_read;
      logic k_sq;
      logic sp_clear;
      logic sp_next;
      logic k_zero;
      logic seg_fill;
      logic sg_init;
      logic div_init;
      logic div_step;
      logic off_load;
      logic seg_clear;
      logic sg_next;
      logic bcd_init;
      logic bcd_step;
      logic cnt_read;
      logic cnt_step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_err;
      logic itr_zero;
      logic k_le_lim;
      logic sq_le_lim;
      logic map_bit;
      logic k_lt_len;
      logic p_le_lim;
      logic out_free;
   } stat_type;

endpackage

/* hdl/spsc_ctrl.sv */
module spsc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  spsc_pkg::stat_type stat,
   output spsc_pkg::cmd_type  cmd
);

   spsc_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new word is taken only while the sequencer is idle.
   assign req_stall = (state_ff != spsc_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spsc_pkg::ST_IDLE: begin
            if (req_valid) state_in = spsc_pkg::ST_CHECK;
         end
         spsc_pkg::ST_CHECK: begin
            state_in = stat.has_err ? spsc_pkg::ST_DONE : spsc_pkg::ST_ROOT;
         end
         spsc_pkg::ST_ROOT: begin
            if (stat.itr_zero) state_in = spsc_pkg::ST_FILL_SP;
         end
         spsc_pkg::ST_FILL_SP: begin
            if (!stat.k_le_lim) state_in = spsc_pkg::ST_SP_TEST;
         end
         spsc_pkg::ST_SP_TEST: begin
            state_in = stat.sq_le_lim ? spsc_pkg::ST_SP_CHK : spsc_pkg::ST_FILL_SEG;
         end
         spsc_pkg::ST_SP_CHK: begin
            state_in = stat.map_bit ? spsc_pkg::ST_SP_STRIKE : spsc_pkg::ST_SP_TEST;
         end
         spsc_pkg::ST_SP_STRIKE: begin
            if (!stat.k_le_lim) state_in = spsc_pkg::ST_SP_TEST;
         end
         spsc_pkg::ST_FILL_SEG: begin
            if (!stat.k_lt_len) state_in = spsc_pkg::ST_SG_TEST;
         end
         spsc_pkg::ST_SG_TEST: begin
            state_in = stat.p_le_lim ? spsc_pkg::ST_SG_CHK : spsc_pkg::ST_BCD;
         end
         spsc_pkg::ST_SG_CHK: begin
            state_in = stat.map_bit ? spsc_pkg::ST_DIV : spsc_pkg::ST_SG_TEST;
         end
         spsc_pkg::ST_DIV: begin
            if (stat.itr_zero) state_in = spsc_pkg::ST_OFF;
         end
         spsc_pkg::ST_OFF: begin
            state_in = spsc_pkg::ST_SG_STRIKE;
         end
         spsc_pkg::ST_SG_STRIKE: begin
            if (!stat.k_lt_len) state_in = spsc_pkg::ST_SG_TEST;
         end
         spsc_pkg::ST_BCD: begin
            if (stat.itr_zero) state_in = spsc_pkg::ST_CNT_TEST;
         end
         spsc_pkg::ST_CNT_TEST: begin
            state_in = stat.k_lt_len ? spsc_pkg::ST_CNT_CHK : spsc_pkg::ST_DONE;
         end
         spsc_pkg::ST_CNT_CHK: begin
            state_in = spsc_pkg::ST_CNT_TEST;
         end
         spsc_pkg::ST_DONE: begin
            if (stat.out_free) state_in = spsc_pkg::ST_IDLE;
         end
         default: state_in = spsc_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         spsc_pkg::ST_IDLE: begin
            cmd.load = req_valid;
         end
         spsc_pkg::ST_CHECK: begin
            cmd.root_init = !stat.has_err;
         end
         spsc_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            cmd.k_two     = stat.itr_zero;
         end
         spsc_pkg::ST_FILL_SP: begin
            cmd.sp_fill = stat.k_le_lim;
            cmd.sp_init = !stat.k_le_lim;
         end
         spsc_pkg::ST_SP_TEST: begin
            cmd.map_read = stat.sq_le_lim;
            cmd.k_zero   = !stat.sq_le_lim;
         end
         spsc_pkg::ST_SP_CHK: begin
            cmd.k_sq    = stat.map_bit;
            cmd.sp_next = !stat.map_bit;
         end
         spsc_pkg::ST_SP_STRIKE: begin
            cmd.sp_clear = stat.k_le_lim;
            cmd.sp_next  = !stat.k_le_lim;
         end
         spsc_pkg::ST_FILL_SEG: begin
            cmd.seg_fill = stat.k_lt_len;
            cmd.sg_init  = !stat.k_lt_len;
         end
         spsc_pkg::ST_SG_TEST: begin
            cmd.map_read = stat.p_le_lim;
            cmd.bcd_init = !stat.p_le_lim;
         end
         spsc_pkg::ST_SG_CHK: begin
            cmd.div_init = stat.map_bit;
            cmd.sg_next  = !stat.map_bit;
         end
         spsc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         spsc_pkg::ST_OFF: begin
            cmd.off_load = 1'b1;
         end
         spsc_pkg::ST_SG_STRIKE: begin
            cmd.seg_clear = stat.k_lt_len;
            cmd.sg_next   = !stat.k_lt_len;
         end
         spsc_pkg::ST_BCD: begin
            cmd.bcd_step = 1'b1;
            cmd.k_zero   = stat.itr_zero;
         end
         spsc_pkg::ST_CNT_TEST: begin
            cmd.cnt_read = stat.k_lt_len;
         end
         spsc_pkg::ST_CNT_CHK: begin
            cmd.cnt_step = 1'b1;
         end
         spsc_pkg::ST_DONE: begin
            cmd.finish = stat.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* hdl/spsc_dp.sv */
module spsc_dp #(
   parameter int VALUE_BITS = 24,
   parameter int SEG_MAX    = 4096,
   parameter int ROOT_MAX   = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spsc_pkg::cmd_type            cmd,
   output spsc_pkg::stat_type           stat,
   input  logic [VALUE_BITS-1:0]        req_seg_start,
   input  logic [VALUE_BITS-1:0]        req_seg_end,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [spsc_pkg::COUNT_W-1:0] rsp_seg_count,
   output logic [spsc_pkg::TOTAL_W-1:0] rsp_grand_total,
   output logic [spsc_pkg::ERR_W-1:0]   rsp_error_code
);

   localparam int RW  = (VALUE_BITS + 1) / 2;
   localparam int PW  = $clog2(ROOT_MAX + 2);
   localparam int SAW = $clog2(ROOT_MAX + 1);
   localparam int SGW = $clog2(SEG_MAX);
   localparam int LW  = $clog2(SEG_MAX + 1);
   localparam int KW  = $clog2(2 * ROOT_MAX + SEG_MAX + 4) + 1;
   localparam int IW  = $clog2(VALUE_BITS);
   localparam int DIG = (VALUE_BITS * 3) / 10 + 2;
   localparam int BW  = DIG * 4;
   localparam int SW  = spsc_pkg::TOTAL_W + 1;

   // Bit maps.
   logic small_map [ROOT_MAX+1];
   logic seg_map   [SEG_MAX];

   logic [VALUE_BITS-1:0]        a_ff, a_in, b_ff, b_in;
   logic [LW-1:0]                len_ff, len_in;
   spsc_pkg::err_type            err_ff, err_in;
   logic [RW-1:0]                root_ff, root_in;
   logic [IW-1:0]                itr_ff, itr_in;
   logic [PW-1:0]                p_ff, p_in;
   logic [KW-1:0]                sq_ff, sq_in;
   logic [KW-1:0]                k_ff, k_in;
   logic [PW-1:0]                rem_ff, rem_in;
   logic [VALUE_BITS-1:0]        dq_ff, dq_in;
   logic [BW-1:0]                bcd_ff, bcd_in;
   logic [VALUE_BITS-1:0]        dd_ff, dd_in;
   logic [LW-1:0]                cnt_ff, cnt_in;
   logic [spsc_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                         map_rd_ff, seg_rd_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [spsc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [spsc_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   spsc_pkg::err_type            rsp_err_ff, rsp_err_in;

   logic [PW-1:0]         lim;
   logic [RW-1:0]         cand;
   logic [2*RW-1:0]       cand_sq;
   logic [PW:0]           div_t;
   logic [BW-1:0]         dab;
   logic [BW-1:0]         bcd_inc;
   logic                  carry;
   logic [3:0]            threes;
   logic                  hit;
   logic [KW-1:0]         offset;
   logic [SW-1:0]         sum;
   logic [VALUE_BITS-1:0] diff;
   logic                  bad_range, too_long;

   // Small-prime limit, clamped to the size of the small map.
   always_comb begin
      if (32'(root_ff) > 32'(ROOT_MAX)) begin
         lim = PW'(ROOT_MAX);
      end else begin
         lim = PW'(root_ff);
      end
   end

   // One bit of the integer square root per step.
   assign cand    = root_ff | (RW'(1) << itr_ff);
   assign cand_sq = (2*RW)'(cand) * (2*RW)'(cand);

   // One quotient bit per step; only the remainder is kept.
   assign div_t = {rem_ff, dq_ff[VALUE_BITS-1]};

   // First struck offset in the segment; the prime itself is skipped.
   always_comb begin
      if (32'(a_ff) <= 32'(p_ff)) begin
         offset = KW'({p_ff, 1'b0}) - KW'(a_ff);
      end else if (rem_ff == '0) begin
         offset = '0;
      end else begin
         offset = KW'(p_ff) - KW'(rem_ff);
      end
   end

   // Double-dabble correction ahead of the shift.
   always_comb begin
      for (int i = 0; i < DIG; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            dab[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            dab[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Decimal increment and count of digits equal to three.
   always_comb begin
      carry  = 1'b1;
      threes = '0;
      for (int i = 0; i < DIG; i++) begin
         if (bcd_ff[4*i +: 4] == 4'd3) threes = threes + 4'd1;
         if (carry && bcd_ff[4*i +: 4] == 4'd9) begin
            bcd_inc[4*i +: 4] = 4'd0;
         end else begin
            bcd_inc[4*i +: 4] = bcd_ff[4*i +: 4] + {3'd0, carry};
            carry = 1'b0;
         end
      end
      hit = seg_rd_ff && (threes >= 4'd2);
   end

   // Range checks on the incoming word.
   assign diff      = req_seg_end - req_seg_start;
   assign bad_range = (req_seg_start < VALUE_BITS'(2)) || (req_seg_end < req_seg_start);
   assign too_long  = 64'(diff) >= 64'(SEG_MAX);

   assign sum = SW'(total_ff) + SW'(cnt_ff);

   // Datapath register updates.
   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      len_in       = len_ff;
      err_in       = err_ff;
      root_in      = root_ff;
      itr_in       = itr_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      bcd_in       = bcd_ff;
      dd_in        = dd_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_total_in = rsp_total_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         a_in   = req_seg_start;
         b_in   = req_seg_end;
         len_in = LW'(diff) + LW'(1);
         cnt_in = '0;
         if (bad_range) begin
            err_in = spsc_pkg::ERR_RANGE;
         end else if (too_long) begin
            err_in = spsc_pkg::ERR_LONG;
         end else begin
            err_in = spsc_pkg::ERR_OK;
         end
      end
      if (cmd.root_init) begin
         root_in = '0;
         itr_in  = IW'(RW - 1);
      end
      if (cmd.root_step) begin
         if (64'(cand_sq) <= 64'(b_ff)) root_in = cand;
         itr_in = itr_ff - IW'(1);
      end
      if (cmd.k_two) k_in = KW'(2);
      if (cmd.sp_fill) k_in = k_ff + KW'(1);
      if (cmd.sp_init) begin
         p_in  = PW'(2);
         sq_in = KW'(4);
      end
      if (cmd.k_sq) k_in = sq_ff;
      if (cmd.sp_clear || cmd.seg_clear) k_in = k_ff + KW'(p_ff);
      if (cmd.sp_next) begin
         p_in  = p_ff + PW'(1);
         sq_in = sq_ff + KW'({p_ff, 1'b1});
      end
      if (cmd.k_zero) k_in = '0;
      if (cmd.seg_fill) k_in = k_ff + KW'(1);
      if (cmd.sg_init) p_in = PW'(2);
      if (cmd.sg_next) p_in = p_ff + PW'(1);
      if (cmd.div_init) begin
         rem_in = '0;
         dq_in  = a_ff;
         itr_in = IW'(VALUE_BITS - 1);
      end
      if (cmd.div_step) begin
         if (div_t >= {1'b0, p_ff}) begin
            rem_in = PW'(div_t - {1'b0, p_ff});
         end else begin
            rem_in = PW'(div_t);
         end
         dq_in  = dq_ff << 1;
         itr_in = itr_ff - IW'(1);
      end
      if (cmd.off_load) k_in = offset;
      if (cmd.bcd_init) begin
         bcd_in = '0;
         dd_in  = a_ff;
         itr_in = IW'(VALUE_BITS - 1);
      end
      if (cmd.bcd_step) begin
         bcd_in = {dab[BW-2:0], dd_ff[VALUE_BITS-1]};
         dd_in  = dd_ff << 1;
         itr_in = itr_ff - IW'(1);
      end
      if (cmd.cnt_step) begin
         if (hit) cnt_in = cnt_ff + LW'(1);
         bcd_in = bcd_inc;
         k_in   = k_ff + KW'(1);
      end
      if (cmd.finish) begin
         if (err_ff == spsc_pkg::ERR_OK) begin
            if (sum > SW'(spsc_pkg::TOTAL_MAX)) begin
               total_in = spsc_pkg::TOTAL_MAX;
            end else begin
               total_in = sum[spsc_pkg::TOTAL_W-1:0];
            end
         end
         rsp_valid_in = 1'b1;
         rsp_count_in = spsc_pkg::COUNT_W'(cnt_ff);
         rsp_total_in = (err_ff == spsc_pkg::ERR_OK) ? total_in : total_ff;
         rsp_err_in   = err_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      len_ff       <= len_in;
      err_ff       <= err_in;
      root_ff      <= root_in;
      itr_ff       <= itr_in;
      p_ff         <= p_in;
      sq_ff        <= sq_in;
      k_ff         <= k_in;
      rem_ff       <= rem_in;
      dq_ff        <= dq_in;
      bcd_ff       <= bcd_in;
      dd_ff        <= dd_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
      rsp_total_ff <= rsp_total_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // Small-prime map: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.sp_fill || cmd.sp_clear) small_map[k_ff[SAW-1:0]] <= cmd.sp_fill;
      if (cmd.map_read) map_rd_ff <= small_map[p_ff[SAW-1:0]];
   end

   // Segment map: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.seg_fill || cmd.seg_clear) seg_map[k_ff[SGW-1:0]] <= cmd.seg_fill;
      if (cmd.cnt_read) seg_rd_ff <= seg_map[k_ff[SGW-1:0]];
   end

   // Status to the controller.
   always_comb begin
      stat.has_err   = (err_ff != spsc_pkg::ERR_OK);
      stat.itr_zero  = (itr_ff == '0);
      stat.k_le_lim  = (k_ff <= KW'(lim));
      stat.sq_le_lim = (sq_ff <= KW'(lim));
      stat.map_bit   = map_rd_ff;
      stat.k_lt_len  = (k_ff < KW'(len_ff));
      stat.p_le_lim  = (p_ff <= lim);
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seg_count   = rsp_count_ff;
   assign rsp_grand_total = rsp_total_ff;
   assign rsp_error_code  = rsp_err_ff;

endmodule

/* hdl/segmented_prime_sieve_counter.sv */
// Segmented prime sieve counter.
// The request channel (req_valid, req_stall, req_seg_start, req_seg_end) takes one
// segment word. The block sieves the small primes up to the root of the segment end,
// strikes their multiples from a segment map, and counts the surviving primes whose
// decimal form holds two or more threes. The response channel (rsp_valid, rsp_stall)
// returns that count, the saturating running total, and an error code.
// Words are handled one at a time. A bad range or an over-long segment skips the sieve
// and goes straight to the result. A good segment's run time grows with its length
// and its limit, since each small prime in range passes through a bit-serial divider
// and the bit maps are filled, struck and read one bit at a time.
// req_stall is low only while the sequencer is idle. A finished result sits in the
// output register, so the next word can be taken while rsp_stall holds the result.
// Synchronous reset clears the sequencer, the output valid and the running total;
// the bit maps need no clearing since each segment writes them before reading.
module segmented_prime_sieve_counter #(
   parameter int VALUE_BITS = 24,
   parameter int SEG_MAX    = 4096,
   parameter int ROOT_MAX   = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [VALUE_BITS-1:0]        req_seg_start,
   input  logic [VALUE_BITS-1:0]        req_seg_end,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [spsc_pkg::COUNT_W-1:0] rsp_seg_count,
   output logic [spsc_pkg::TOTAL_W-1:0] rsp_grand_total,
   output logic [spsc_pkg::ERR_W-1:0]   rsp_error_code
);

   spsc_pkg::cmd_type  cmd;
   spsc_pkg::stat_type stat;

   // Sequencer.
   spsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Maps, arithmetic units and output register.
   spsc_dp #(
      .VALUE_BITS (VALUE_BITS),
      .SEG_MAX    (SEG_MAX),
      .ROOT_MAX   (ROOT_MAX)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_seg_start   (req_seg_start),
      .req_seg_end     (req_seg_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_seg_count   (rsp_seg_count),
      .rsp_grand_total (rsp_grand_total),
      .rsp_error_code  (rsp_error_code)
   );

endmodule

/* hdl/spsc_chk.sv */
module spsc_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [spsc_pkg::COUNT_W-1:0] rsp_seg_count,
   input logic [spsc_pkg::TOTAL_W-1:0] rsp_grand_total,
   input logic [spsc_pkg::ERR_W-1:0]   rsp_error_code
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seg_count)
         && $stable(rsp_grand_total) && $stable(rsp_error_code))
      else $error("stalled result word changed");

   // Once a word is taken, the block is busy on the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

   // A rejected segment reports no primes.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != spsc_pkg::ERR_OK) |-> rsp_seg_count == '0)
      else $error("error result with nonzero count");

   // A good result's count is included in the running total.
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == spsc_pkg::ERR_OK)
         |-> rsp_grand_total >= spsc_pkg::TOTAL_W'(rsp_seg_count))
      else $error("running total below segment count");

endmodule

bind segmented_prime_sieve_counter spsc_chk u_spsc_chk (.*);

/* dv/testbench.sv */
module testbench;

   localparam int VBITS    = 24;
   localparam int SEG_LIM  = 4096;
   localparam int ROOT_LIM = 4096;

   // One predicted result word.
   typedef struct {
      logic [spsc_pkg::COUNT_W-1:0] count;
      logic [spsc_pkg::TOTAL_W-1:0] total;
      spsc_pkg::err_type            code;
   } sieve_result_type;

   // Scoreboard: predicts each segment and checks results in order.
   class sieve_scoreboard;
      sieve_result_type              pending[$];
      int                            mismatches;
      logic [spsc_pkg::TOTAL_W-1:0]  total;
      bit                            prime_map[0:ROOT_LIM];
      bit                            live_map[0:SEG_LIM-1];

      function new();
         mismatches = 0;
         total      = '0;
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d want %0d", what, got, want);
         mismatches++;
      endtask

      function bit two_threes(longint v);
         int n;
         n = 0;
         while (v > 0) begin
            if (v % 10 == 3) n++;
            v = v / 10;
         end
         return n >= 2;
      endfunction

      function longint root_of(longint v);
         longint r;
         longint c;
         r = 0;
         for (int i = 15; i >= 0; i--) begin
            c = r | (longint'(1) << i);
            if (c * c <= v) r = c;
         end
         return r;
      endfunction

      // Sieve the segment and count survivors with two or more threes.
      function int count_segment(longint a, longint b);
         longint len;
         longint lim;
         longint first;
         int     n;
         len = b - a + 1;
         lim = root_of(b);
         if (lim > ROOT_LIM) lim = ROOT_LIM;
         n = 0;
         prime_map[0] = 0;
         prime_map[1] = 0;
         for (longint p = 2; p <= lim; p++) prime_map[p] = 1;
         for (longint p = 2; p * p <= lim; p++)
            if (prime_map[p])
               for (longint k = p * p; k <= lim; k += p) prime_map[k] = 0;
         for (longint k = 0; k < len; k++) live_map[k] = 1;
         for (longint p = 2; p <= lim; p++) begin
            if (prime_map[p]) begin
               first = ((a + p - 1) / p) * p;
               if (first <= p) first = 2 * p;
               for (longint k = first - a; k < len; k += p) live_map[k] = 0;
            end
         end
         for (longint k = 0; k < len; k++)
            if (live_map[k] && two_threes(a + k)) n++;
         return n;
      endfunction

      // Note an accepted segment word and queue its expected result.
      function void note_segment(logic [VBITS-1:0] s, logic [VBITS-1:0] e);
         sieve_result_type r;
         longint a;
         longint b;
         longint sum;
         int     n;
         a = s;
         b = e;
         r.count = '0;
         if (a < 2 || b < a) begin
            r.code = spsc_pkg::ERR_RANGE;
         end else if (b - a + 1 > SEG_LIM) begin
            r.code = spsc_pkg::ERR_LONG;
         end else begin
            r.code  = spsc_pkg::ERR_OK;
            n       = count_segment(a, b);
            r.count = n[spsc_pkg::COUNT_W-1:0];
            sum = longint'(total) + r.count;
            if (sum > longint'(spsc_pkg::TOTAL_MAX)) sum = spsc_pkg::TOTAL_MAX;
            total = sum[spsc_pkg::TOTAL_W-1:0];
         end
         r.total = total;
         pending.push_back(r);
      endfunction

      // Compare one accepted result word with the oldest expectation.
      task check_result(logic [spsc_pkg::COUNT_W-1:0] c, logic [spsc_pkg::TOTAL_W-1:0] t,
                        logic [spsc_pkg::ERR_W-1:0] ec);
         sieve_result_type r;
         if (pending.size() == 0) begin
            $display("unexpected result word count %0d total %0d", c, t);
            mismatches++;
            return;
         end
         r = pending.pop_front();
         if (c !== r.count) report("seg_count", c, r.count);
         if (t !== r.total) report("grand_total", t, r.total);
         if (ec !== r.code) report("error_code", ec, r.code);
      endtask
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   logic [VBITS-1:0] req_seg_start = '0;
   logic [VBITS-1:0] req_seg_end = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1;
   logic [spsc_pkg::COUNT_W-1:0] rsp_seg_count;
   logic [spsc_pkg::TOTAL_W-1:0] rsp_grand_total;
   logic [spsc_pkg::ERR_W-1:0]   rsp_error_code;

   sieve_scoreboard sb = new();

   segmented_prime_sieve_counter #(
      .VALUE_BITS(VBITS), .SEG_MAX(SEG_LIM), .ROOT_MAX(ROOT_LIM)
   ) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_seg_start(req_seg_start), .req_seg_end(req_seg_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_seg_count(rsp_seg_count), .rsp_grand_total(rsp_grand_total),
      .rsp_error_code(rsp_error_code)
   );

   always #6 clock = ~clock;

   // Offer one segment word after a random gap and wait until it is taken.
   task automatic send_segment(logic [VBITS-1:0] s, logic [VBITS-1:0] e);
      int gap;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1;
      req_seg_start <= s;
      req_seg_end   <= e;
      do @(posedge clock); while (req_stall);
      sb.note_segment(s, e);
   endtask

   // Draw a random segment; most are cheap, a few reach large values or lengths.
   task automatic send_random();
      int          pick;
      logic [VBITS-1:0] s;
      logic [VBITS-1:0] e;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         s = VBITS'($urandom_range(2, 70000));
         e = VBITS'(s + $urandom_range(0, 63));
      end else if (pick < 65) begin
         s = VBITS'($urandom_range(3000, 3400));
         e = VBITS'(s + $urandom_range(0, 127));
      end else if (pick < 75) begin
         e = VBITS'($urandom_range(1 << 20, (1 << VBITS) - 1));
         s = VBITS'(e - $urandom_range(0, 31));
      end else if (pick < 78) begin
         s = VBITS'($urandom_range(2, 60000));
         e = VBITS'(s + $urandom_range(1024, SEG_LIM - 1));
      end else if (pick < 88) begin
         s = VBITS'($urandom_range(0, (1 << VBITS) - 1));
         e = VBITS'($urandom_range(0, (1 << VBITS) - 1));
      end else begin
         s = VBITS'($urandom_range(0, 1));
         e = VBITS'($urandom_range(0, (1 << VBITS) - 1));
      end
      send_segment(s, e);
   endtask

   // Result side: a long hold-off first so the block backs up, then random stalls.
   initial begin
      int wait_cycles;
      wait_cycles = 300;
      @(negedge reset);
      forever begin
         if (wait_cycles > 0) begin
            rsp_stall <= 1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_seg_count, rsp_grand_total, rsp_error_code);
         wait_cycles = $urandom_range(0, 7);
      end
   end

   // Stimulus and end of run.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Bad ranges and over-long segments first; these pile up behind the hold-off.
      send_segment(0, 0);
      send_segment(1, 5);
      send_segment(10, 9);
      send_segment(24'hFFFFFF, 0);
      send_segment(0, 24'hFFFFFF);
      send_segment(2, 4098);
      send_segment(2, 24'hFFFFFF);
      // Good segments at the edges of the value range and of the length.
      send_segment(2, 2);
      send_segment(2, 3);
      send_segment(33, 33);
      send_segment(233, 233);
      send_segment(330, 340);
      send_segment(3300, 3399);
      send_segment(24'hFFFFFF, 24'hFFFFFF);
      send_segment(24'hFFFF00, 24'hFFFFFF);
      send_segment(24'h800000, 24'h800010);
      send_segment(2, 4097);
      send_segment(24'hFFF000, 24'hFFFFFF);
      for (int i = 0; i < 100; i++) send_random();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(12 * 30_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
hdl/spsc_pkg.sv
hdl/spsc_ctrl.sv
hdl/spsc_dp.sv
hdl/segmented_prime_sieve_counter.sv
hdl/spsc_chk.sv
dv/testbench.sv
